// ===== rtl/sct_pkg.sv =====
// Package for the sorted counted item table: sizes, opcodes, item and slot
// structs, controller states. No dependencies; every other rtl file imports it.
`default_nettype none

package sct_pkg;

  localparam int SLOTS      = 16;
  localparam int ID_BITS    = 8;
  localparam int COUNT_BITS = 16;
  localparam int KEY_BITS   = 16;
  localparam int POS_W      = 5;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);

  localparam logic OP_GIVE   = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic                       op;
    logic [ID_BITS-1:0]         item_id;
    logic [COUNT_BITS-1:0]      amount;
    logic [COUNT_BITS-1:0]      max_amount;
    logic                       full_only;
    logic signed [KEY_BITS-1:0] sort_key;
    logic                       keep_depleted;
  } req_t;

  typedef struct packed {
    logic                  accepted;
    logic [COUNT_BITS-1:0] held_amount;
    logic [POS_W-1:0]      position;
  } rsp_t;

  typedef struct packed {
    logic                       used;
    logic [ID_BITS-1:0]         item;
    logic [COUNT_BITS-1:0]      count;
    logic signed [KEY_BITS-1:0] key;
  } slot_t;

  // Results of the shared compare / count unit.
  typedef struct packed {
    logic                  id_hit;
    logic                  key_ge;
    logic                  over;
    logic                  ge;
    logic                  zero;
    logic [COUNT_BITS-1:0] give_cnt;
    logic [COUNT_BITS-1:0] diff;
  } unit_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT_UP,
    ST_SHIFT_DN
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/sct_store.sv =====
// Slot register file: one read port (combinational select), one write port.
// Depends on sct_pkg for slot_t and the table size.
`default_nettype none

module sct_store (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [sct_pkg::IDX_W-1:0] rd_idx_i,
  output sct_pkg::slot_t                rd_slot_o,
  input  wire logic                     wr_en_i,
  input  wire logic [sct_pkg::IDX_W-1:0] wr_idx_i,
  input  wire sct_pkg::slot_t           wr_slot_i
);
  import sct_pkg::*;

  logic [SLOTS-1:0]           used_q;
  logic [ID_BITS-1:0]         item_q  [SLOTS];
  logic [COUNT_BITS-1:0]      count_q [SLOTS];
  logic signed [KEY_BITS-1:0] key_q   [SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (wr_en_i) begin
      used_q[wr_idx_i] <= wr_slot_i.used;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      item_q[wr_idx_i]  <= wr_slot_i.item;
      count_q[wr_idx_i] <= wr_slot_i.count;
      key_q[wr_idx_i]   <= wr_slot_i.key;
    end
  end

  // A free slot reads with a zero count.
  always_comb begin
    rd_slot_o.used  = used_q[rd_idx_i];
    rd_slot_o.item  = item_q[rd_idx_i];
    rd_slot_o.count = used_q[rd_idx_i] ? count_q[rd_idx_i] : '0;
    rd_slot_o.key   = key_q[rd_idx_i];
  end

endmodule

`default_nettype wire

// ===== rtl/sct_unit.sv =====
// Shared compare and count unit: id match and key order during the scan,
// saturating add and checked subtract at the decision step. Uses sct_pkg.
`default_nettype none

module sct_unit (
  input  wire sct_pkg::req_t                  req_i,
  input  wire sct_pkg::slot_t                 slot_i,
  input  wire logic [sct_pkg::COUNT_BITS-1:0] base_cnt_i,
  output sct_pkg::unit_res_t                  res_o
);
  import sct_pkg::*;

  logic [COUNT_BITS:0] sum;

  always_comb begin
    sum            = {1'b0, base_cnt_i} + {1'b0, req_i.amount};
    res_o.id_hit   = slot_i.used && (slot_i.item == req_i.item_id);
    res_o.key_ge   = $signed(slot_i.key) >= $signed(req_i.sort_key);
    res_o.over     = sum > {1'b0, req_i.max_amount};
    res_o.give_cnt = res_o.over ? req_i.max_amount : sum[COUNT_BITS-1:0];
    res_o.ge       = base_cnt_i >= req_i.amount;
    res_o.diff     = base_cnt_i - req_i.amount;
    res_o.zero     = (res_o.diff == '0);
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_counted_item_table_top.sv =====
// Sorted counted item table, top level: sequencer, slot store, shared unit.
// Steps: scan (one slot per cycle up to the match or first free slot), decide,
// shift slots up on an insert or down on a delete, then the result register.
// Throughput: one item at a time; busy stays high until the result strobe, and
// the next item can be taken in the strobe cycle.
// Reset (async, active low) frees every slot; the receiver cannot stall.
// Depends on sct_pkg, sct_store and sct_unit.
`default_nettype none

module sorted_counted_item_table_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   start,
  input  wire sct_pkg::req_t req_i,
  output logic        busy,
  output logic        valid_o,
  output sct_pkg::rsp_t rsp_o
);
  import sct_pkg::*;

  state_e                state_q, state_d;
  req_t                  req_q;
  logic [CNT_W-1:0]      idx_q;
  logic                  hit_q, free_q, ins_q;
  logic [IDX_W-1:0]      hit_idx_q, free_idx_q, ins_idx_q;
  slot_t                 hit_slot_q;
  logic [COUNT_BITS-1:0] new_cnt_q;
  logic                  valid_q;
  rsp_t                  rsp_q;

  logic [IDX_W-1:0]      rd_idx;
  slot_t                 rd_slot;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  slot_t                 wr_slot;
  logic [COUNT_BITS-1:0] base_cnt;
  unit_res_t             ures;

  logic                  fin;
  rsp_t                  fin_rsp;
  logic                  refuse_over, g_hit_ok, g_new_ok, r_ok, r_del;
  logic                  scan_last;
  logic [IDX_W-1:0]      idx;

  assign idx       = idx_q[IDX_W-1:0];
  assign scan_last = (idx_q == CNT_W'(SLOTS - 1));
  assign busy      = (state_q != ST_IDLE);
  assign valid_o   = valid_q;
  assign rsp_o     = rsp_q;

  // Fresh items start from zero; a hit works on the count seen in the scan.
  assign base_cnt    = hit_q ? hit_slot_q.count : '0;
  assign refuse_over = req_q.full_only && ures.over;
  assign g_hit_ok    = (req_q.op == OP_GIVE) && hit_q && !refuse_over;
  assign g_new_ok    = (req_q.op == OP_GIVE) && !hit_q && free_q && !refuse_over;
  assign r_ok        = (req_q.op == OP_REMOVE) && hit_q && ures.ge;
  assign r_del       = r_ok && ures.zero && !req_q.keep_depleted;

  sct_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (rd_idx),
    .rd_slot_o (rd_slot),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_slot_i (wr_slot)
  );

  sct_unit u_unit (
    .req_i      (req_q),
    .slot_i     (rd_slot),
    .base_cnt_i (base_cnt),
    .res_o      (ures)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        // Stop on a match, on the first free slot (table is packed), or at the end.
        if (ures.id_hit || !rd_slot.used || scan_last) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (g_new_ok && ins_q) begin
          state_d = ST_SHIFT_UP;
        end else if (r_del) begin
          state_d = ST_SHIFT_DN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SHIFT_UP: begin
        if (idx == ins_idx_q) state_d = ST_IDLE;
      end
      ST_SHIFT_DN: begin
        if (scan_last || !rd_slot.used) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Store access and result for the current step.
  always_comb begin
    rd_idx           = idx;
    wr_en            = 1'b0;
    wr_idx           = idx;
    wr_slot          = rd_slot;
    fin              = 1'b0;
    fin_rsp.accepted    = 1'b0;
    fin_rsp.held_amount = '0;
    fin_rsp.position    = POS_W'(SLOTS);
    case (state_q)
      ST_DECIDE: begin
        fin = !((g_new_ok && ins_q) || r_del);
        if (g_hit_ok) begin
          wr_en               = 1'b1;
          wr_idx              = hit_idx_q;
          wr_slot             = hit_slot_q;
          wr_slot.count       = ures.give_cnt;
          fin_rsp.accepted    = 1'b1;
          fin_rsp.held_amount = ures.give_cnt;
          fin_rsp.position    = POS_W'(hit_idx_q);
        end else if (g_new_ok && !ins_q) begin
          wr_en               = 1'b1;
          wr_idx              = free_idx_q;
          wr_slot.used        = 1'b1;
          wr_slot.item        = req_q.item_id;
          wr_slot.count       = ures.give_cnt;
          wr_slot.key         = req_q.sort_key;
          fin_rsp.accepted    = 1'b1;
          fin_rsp.held_amount = ures.give_cnt;
          fin_rsp.position    = POS_W'(free_idx_q);
        end else if (r_ok && !r_del) begin
          wr_en               = 1'b1;
          wr_idx              = hit_idx_q;
          wr_slot             = hit_slot_q;
          wr_slot.count       = ures.diff;
          fin_rsp.accepted    = 1'b1;
          fin_rsp.held_amount = ures.diff;
          fin_rsp.position    = POS_W'(hit_idx_q);
        end else if (hit_q && !r_del && !g_new_ok) begin
          // Refused on an entry that stays as it stands.
          fin_rsp.held_amount = hit_slot_q.count;
          fin_rsp.position    = POS_W'(hit_idx_q);
        end
      end
      ST_SHIFT_UP: begin
        // Move slot idx-1 up into idx; at the insertion point drop in the new entry.
        rd_idx = idx - IDX_W'(1);
        wr_en  = 1'b1;
        if (idx == ins_idx_q) begin
          wr_slot.used        = 1'b1;
          wr_slot.item        = req_q.item_id;
          wr_slot.count       = new_cnt_q;
          wr_slot.key         = req_q.sort_key;
          fin                 = 1'b1;
          fin_rsp.accepted    = 1'b1;
          fin_rsp.held_amount = new_cnt_q;
          fin_rsp.position    = POS_W'(ins_idx_q);
        end
      end
      ST_SHIFT_DN: begin
        // Pull slot idx+1 down into idx; the top slot gets cleared.
        rd_idx = idx + IDX_W'(1);
        wr_en  = 1'b1;
        if (scan_last) begin
          wr_slot.used  = 1'b0;
          wr_slot.count = '0;
        end
        if (scan_last || !rd_slot.used) begin
          fin              = 1'b1;
          fin_rsp.accepted = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) rsp_q <= fin_rsp;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_q  <= req_i;
          idx_q  <= '0;
          hit_q  <= 1'b0;
          free_q <= 1'b0;
          ins_q  <= 1'b0;
        end
      end
      ST_SCAN: begin
        if (ures.id_hit) begin
          hit_q      <= 1'b1;
          hit_idx_q  <= idx;
          hit_slot_q <= rd_slot;
        end else if (!rd_slot.used) begin
          free_q     <= 1'b1;
          free_idx_q <= idx;
        end else begin
          if (!ins_q && ures.key_ge) begin
            ins_q     <= 1'b1;
            ins_idx_q <= idx;
          end
          idx_q <= idx_q + CNT_W'(1);
        end
      end
      ST_DECIDE: begin
        new_cnt_q <= ures.give_cnt;
        if (g_new_ok && ins_q) begin
          idx_q <= CNT_W'(free_idx_q);
        end else begin
          idx_q <= CNT_W'(hit_idx_q);
        end
      end
      ST_SHIFT_UP: begin
        idx_q <= idx_q - CNT_W'(1);
      end
      ST_SHIFT_DN: begin
        idx_q <= idx_q + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !valid_o) else $error("accepted item did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("result shown while still busy");

  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (rsp_o.position == POS_W'(SLOTS)) |-> (rsp_o.held_amount == '0))
    else $error("absent item reported with a nonzero count");
`endif

endmodule

`default_nettype wire

// ===== test/tb_sorted_counted_item_table_top.sv =====
// Testbench for sorted_counted_item_table_top: directed and random give / remove
// items checked against a slot table predictor. Depends on sct_pkg and the rtl.
`timescale 1ns / 100ps

module tb_sorted_counted_item_table_top;
  import sct_pkg::*;

  // Predicted slot table plus the queue of responses still owed by the block.
  class slot_table_model;
    slot_t tbl[SLOTS];
    rsp_t  owed_rsp_q[$];
    int    errors;
    int    taken;
    int    refused;
    int    moved;
    int    deleted;
    int    checked;

    function new();
      foreach (tbl[i]) tbl[i] = '0;
    endfunction

    function int find_id(logic [ID_BITS-1:0] id);
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl[i].used && tbl[i].item == id) return i;
      end
      return -1;
    endfunction

    function logic [COUNT_BITS-1:0] held_of(logic [ID_BITS-1:0] id);
      int p;
      p = find_id(id);
      return (p < 0) ? '0 : tbl[p].count;
    endfunction

    function int pending();
      return owed_rsp_q.size();
    endfunction

    task report(string msg);
      errors++;
      $display("%t MISMATCH: %s", $realtime, msg);
    endtask

    // Apply one accepted item to the table and queue the response it owes.
    function void note_request(req_t r);
      int            pos;
      int            n;
      bit            fresh;
      bit            ok;
      bit            shifted;
      logic [16:0]   sum;
      slot_t         tmp;
      rsp_t          rsp;
      taken++;
      ok  = 1'b0;
      pos = find_id(r.item_id);
      if (r.op == OP_GIVE) begin
        fresh = 1'b0;
        if (pos < 0) begin
          fresh = 1'b1;
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!tbl[i].used) pos = i;
          end
        end
        if (pos >= 0) begin
          sum = (fresh ? 17'd0 : {1'b0, tbl[pos].count}) + {1'b0, r.amount};
          if (r.full_only && sum > {1'b0, r.max_amount}) begin
            // refuse the whole give; a new item stays absent
            if (fresh) pos = -1;
          end else begin
            if (sum > {1'b0, r.max_amount}) sum = {1'b0, r.max_amount};
            tbl[pos].used  = 1'b1;
            tbl[pos].item  = r.item_id;
            tbl[pos].count = sum[COUNT_BITS-1:0];
            if (fresh) tbl[pos].key = r.sort_key;
            ok = 1'b1;
            if (fresh && pos > 0) begin
              // move the new entry in front of the first entry with key not smaller
              n       = pos;
              shifted = 1'b0;
              for (int i = 0; i < n && !shifted; i++) begin
                if (tbl[i].used && $signed(tbl[i].key) >= $signed(tbl[n].key)) begin
                  tmp = tbl[n];
                  for (int j = n; j > i; j--) tbl[j] = tbl[j-1];
                  tbl[i]  = tmp;
                  pos     = i;
                  shifted = 1'b1;
                  moved++;
                end
              end
            end
          end
        end
      end else if (pos >= 0) begin
        if (tbl[pos].count >= r.amount) begin
          tbl[pos].count = tbl[pos].count - r.amount;
          ok = 1'b1;
          if (tbl[pos].count == '0 && !r.keep_depleted) begin
            // pack downward and clear the top slot
            for (int j = pos; j < SLOTS - 1; j++) tbl[j] = tbl[j+1];
            tbl[SLOTS-1] = '0;
            pos = -1;
            deleted++;
          end
        end
      end
      if (!ok) refused++;
      rsp.accepted    = ok;
      rsp.held_amount = (pos >= 0) ? tbl[pos].count : '0;
      rsp.position    = (pos >= 0) ? pos[POS_W-1:0] : SLOTS[POS_W-1:0];
      owed_rsp_q.push_back(rsp);
    endfunction

    task check_response(rsp_t got);
      rsp_t want;
      if (owed_rsp_q.size() == 0) begin
        report($sformatf("response %p with no item waiting", got));
      end else begin
        want = owed_rsp_q.pop_front();
        checked++;
        if (got.accepted !== want.accepted)
          report($sformatf("accepted %b, predicted %b", got.accepted, want.accepted));
        if (got.held_amount !== want.held_amount)
          report($sformatf("held_amount %0d, predicted %0d",
                           got.held_amount, want.held_amount));
        if (got.position !== want.position)
          report($sformatf("position %0d, predicted %0d", got.position, want.position));
      end
    endtask
  endclass

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start  = 1'b0;
  req_t  req_i  = '0;
  logic  busy;
  logic  valid_o;
  rsp_t  rsp_o;

  slot_table_model board = new();

  // Idle control: quiet stretches drive back to back items.
  bit                 quiet;
  logic [ID_BITS-1:0] id_pool[28];
  int                 pool_sizes[4] = '{6, 12, 20, 28};

  sorted_counted_item_table_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .req_i   (req_i),
    .busy    (busy),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  always #6 clk_i = ~clk_i;

  // Sample on the edge: values read here are the ones the block saw.
  // Check before noting, since a strobe may share an edge with a new item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o === 1'b1) board.check_response(rsp_o);
      if (start && busy === 1'b0) board.note_request(req_i);
    end
  end

  // Hold one item on the inputs until the block takes it, then at times idle a while.
  task automatic push_item(req_t r);
    int          gap;
    int          pick;
    logic [63:0] junk;
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    pick = $urandom_range(0, 99);
    if (quiet || pick < 55) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 80);
    if (gap > 0) begin
      // drop start and scramble the payload; the block must ignore it
      junk  = {$urandom, $urandom};
      start <= 1'b0;
      req_i <= junk[$bits(req_t)-1:0];
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send(logic op, logic [ID_BITS-1:0] id, logic [COUNT_BITS-1:0] amt,
                      logic [COUNT_BITS-1:0] maxv, logic full, int key, logic keep);
    req_t r;
    r.op            = op;
    r.item_id       = id;
    r.amount        = amt;
    r.max_amount    = maxv;
    r.full_only     = full;
    r.sort_key      = KEY_BITS'(key);
    r.keep_depleted = keep;
    push_item(r);
  endtask

  // Stop sending until every owed response has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending() > 0) @(posedge clk_i);
  endtask

  // Mostly well-formed traffic on a small id pool, with some raw noise.
  function automatic req_t random_item(int pool_n, bit tie_keys);
    req_t        r;
    logic [63:0] raw;
    int          sel;
    raw = {$urandom, $urandom};
    r   = raw[$bits(req_t)-1:0];
    if ($urandom_range(0, 99) < 8) return r;
    r.item_id = id_pool[$urandom_range(0, pool_n - 1)];
    r.op      = ($urandom_range(0, 99) < 55) ? OP_GIVE : OP_REMOVE;
    sel = $urandom_range(0, 9);
    if (sel < 5) r.amount = COUNT_BITS'($urandom_range(0, 20));
    else if (sel == 7) r.amount = '0;
    else if (sel == 8) r.amount = '1;
    // remove exactly what is held to reach deletion often
    if (r.op == OP_REMOVE && $urandom_range(0, 99) < 45) r.amount = board.held_of(r.item_id);
    sel = $urandom_range(0, 9);
    if (sel < 7) r.max_amount = '1;
    else if (sel == 9) r.max_amount = COUNT_BITS'($urandom_range(0, 50));
    r.full_only     = ($urandom_range(0, 3) == 0);
    r.keep_depleted = ($urandom_range(0, 9) < 3);
    if (tie_keys) r.sort_key = KEY_BITS'(int'($urandom_range(0, 7)) - 4);
    return r;
  endfunction

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: corners of every field and each refusal path.
    quiet = 1'b0;
    send(OP_REMOVE, 8'h5A, 16'd1, 16'hFFFF, 1'b0, 0, 1'b0);          // remove from empty table
    send(OP_GIVE, 8'h00, 16'd0, 16'hFFFF, 1'b0, 0, 1'b0);            // new entry holding zero
    send(OP_GIVE, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, -32768, 1'b0);    // lowest key goes in front
    send(OP_GIVE, 8'hFF, 16'd1, 16'hFFFF, 1'b0, 0, 1'b1);            // saturate at the ceiling
    send(OP_GIVE, 8'hFF, 16'd0, 16'd100, 1'b0, 0, 1'b0);             // cut to a lower ceiling
    send(OP_GIVE, 8'hFF, 16'd1, 16'd100, 1'b1, 0, 1'b0);             // full-amount refusal, held
    send(OP_GIVE, 8'h5A, 16'd200, 16'd100, 1'b1, 32767, 1'b0);       // full-amount refusal, new
    send(OP_GIVE, 8'h5A, 16'd10, 16'hFFFF, 1'b0, 32767, 1'b0);       // highest key stays on top
    send(OP_REMOVE, 8'h5A, 16'd11, 16'hFFFF, 1'b0, 0, 1'b0);         // remove more than held
    send(OP_REMOVE, 8'h5A, 16'd10, 16'hFFFF, 1'b0, 0, 1'b1);         // keep a depleted entry
    send(OP_REMOVE, 8'h00, 16'd0, 16'hFFFF, 1'b0, 0, 1'b0);          // delete slot 1, pack down
    for (int k = 0; k < 14; k++) begin
      // fill the table with keys landing in the middle
      send(OP_GIVE, ID_BITS'(8'h21 + k * 13), COUNT_BITS'(k + 1), 16'hFFFF, 1'b0,
           (k % 2) ? k * 1000 : -k * 2000, 1'b0);
    end
    send(OP_GIVE, 8'h03, 16'd5, 16'hFFFF, 1'b0, 0, 1'b0);            // table full
    send(OP_REMOVE, ID_BITS'(8'h21 + 6 * 13), 16'd7, 16'hFFFF, 1'b0, 0, 1'b0); // delete mid
    drain();

    // Random part: four phases with different id pools and key spreads.
    for (int ph = 0; ph < 4; ph++) begin
      foreach (id_pool[k]) id_pool[k] = ID_BITS'($urandom);
      for (int n = 0; n < 475; n++) begin
        if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
        if (n > 0 && $urandom_range(0, 149) == 0) drain();
        push_item(random_item(pool_sizes[ph], ph[0]));
      end
      drain();
    end

    // Keep the clock running after the drain to catch stray strobes.
    repeat (40) @(posedge clk_i);
    $display("run covered %0d items: %0d refused, %0d entries moved on insert, %0d deleted",
             board.taken, board.refused, board.moved, board.deleted);
    $display("%0d responses checked, %0d mismatches", board.checked, board.errors);
    if (board.errors == 0) begin
      $display("tb_sorted_counted_item_table_top: clean");
    end else begin
      $display("tb_sorted_counted_item_table_top: errors");
    end
    $finish;
  end

  // Drop the run if the block hangs.
  initial begin
    #20ms;
    $display("timeout with %0d responses outstanding", board.pending());
    $display("tb_sorted_counted_item_table_top: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sct_pkg.sv
rtl/sct_store.sv
rtl/sct_unit.sv
rtl/sorted_counted_item_table_top.sv
test/tb_sorted_counted_item_table_top.sv
